FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and status codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] data;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] prio;
    logic signed [31:0] data;
  } result_t;

endpackage

FILE: src/spq_if.sv
// ----------------------------------------------------------------------------
// spq request and result channels
// valid/ready channels that carry queue requests and their results
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] priority_value;
  logic signed [31:0] data_value;

  modport source (output valid, output mode, output priority_value,
                  output data_value, input ready);
  modport sink   (input valid, input mode, input priority_value,
                  input data_value, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] out_priority;
  logic signed [31:0] out_data;

  modport source (output valid, output status, output out_priority,
                  output out_data, input ready);
  modport sink   (input valid, input status, input out_priority,
                  input out_data, output ready);
endinterface

FILE: src/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue kept sorted in a circular memory; smallest priority
// leaves first, equal priorities leave in arrival order
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                               | per request
//  ---------+-----+---------------------------------------+----------------
//  in_i     | in  | mode, priority_value, data_value      | one request
//  out_o    | out | status, out_priority, out_data        | one result
//
// steps: a remove reads the head, takes the data in ST_DEQ and hands off in
//   ST_OUT; an insert into an empty queue is stored at the tail and goes to
//   ST_OUT; any other insert walks the stored entries from the tail in ST_INS,
//   one per cycle, shifting each larger one up, then ST_PUT if all were larger,
//   then ST_OUT; underflow and overflow go straight to ST_OUT
// reset: clears the state, pointers, fill count and output valid only; the entry
//   memory is not cleared, entries at or beyond the fill count are never read
// stalls: in_i.ready is high only while idle; a finished result sits in the
//   output register so a new request can be taken while out_o is stalled
//
module stable_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;  // walk from tail, shift larger ones up
  localparam logic [2:0] ST_PUT  = 3'd2;  // new entry lands at the head slot
  localparam logic [2:0] ST_DEQ  = 3'd3;  // head data is back from memory
  localparam logic [2:0] ST_OUT  = 3'd4;  // hand result to the output register

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;    // next free slot
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;      // slot whose data is in rd_data_q
  logic [CW-1:0]    left_q, left_d;    // entries not yet compared
  spq_pkg::entry_t  new_q, new_d;
  spq_pkg::result_t res_q, res_d;
  spq_pkg::result_t out_q;
  logic             out_valid_q;

  // entry memory, one write and one registered read per cycle
  spq_pkg::entry_t  mem_q [CAPACITY];
  spq_pkg::entry_t  rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  spq_pkg::entry_t  wr_data;

  logic in_fire;
  logic out_free;
  logic larger;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  // the compare shared by every step of the insert walk
  assign larger     = (rd_data_q.prio > new_q.prio);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    idx_d   = idx_q;
    left_d  = left_q;
    new_d   = new_q;
    res_d   = res_q;
    rd_addr = ptr_dec(idx_q);
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = new_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          new_d.prio = in_i.priority_value;
          new_d.data = in_i.data_value;
          res_d      = '{status: spq_pkg::STATUS_OK, prio: '0, data: '0};
          if (in_i.mode == spq_pkg::MODE_REMOVE) begin
            rd_addr = head_q;
            if (count_q == '0) begin
              res_d.status = spq_pkg::STATUS_UNDERFLOW;
              state_d      = ST_OUT;
            end else begin
              state_d = ST_DEQ;
            end
          end else if (count_q == FULL_CNT) begin
            res_d.status = spq_pkg::STATUS_OVERFLOW;
            state_d      = ST_OUT;
          end else if (count_q == '0) begin
            // empty queue: store straight at the tail
            wr_en        = 1'b1;
            wr_addr      = tail_q;
            wr_data.prio = in_i.priority_value;
            wr_data.data = in_i.data_value;
            tail_d       = ptr_inc(tail_q);
            count_d      = count_q + CW'(1);
            state_d      = ST_OUT;
          end else begin
            rd_addr = ptr_dec(tail_q);
            idx_d   = ptr_dec(tail_q);
            left_d  = count_q;
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        wr_en = 1'b1;
        if (larger) begin
          // move the larger entry one slot toward the tail
          wr_addr = ptr_inc(idx_q);
          wr_data = rd_data_q;
          if (left_q == CW'(1)) begin
            state_d = ST_PUT;
          end else begin
            idx_d  = ptr_dec(idx_q);
            left_d = left_q - CW'(1);
          end
        end else begin
          // stop behind the first entry with priority <= new one
          wr_addr = ptr_inc(idx_q);
          wr_data = new_q;
          tail_d  = ptr_inc(tail_q);
          count_d = count_q + CW'(1);
          state_d = ST_OUT;
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = new_q;
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + CW'(1);
        state_d = ST_OUT;
      end
      ST_DEQ: begin
        res_d.prio = rd_data_q.prio;
        res_d.data = rd_data_q.data;
        head_d     = ptr_inc(head_q);
        count_d    = count_q - CW'(1);
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    left_q <= left_d;
    new_q  <= new_d;
    res_q  <= res_d;
    if (state_q == ST_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.out_priority = out_q.prio;
  assign out_o.out_data     = out_q.data;

  // fill count stays within the memory
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("fill count above capacity");

  // a remove from an empty queue ends in an underflow result
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.mode == spq_pkg::MODE_REMOVE && count_q == '0
    |=> state_q == ST_OUT && res_q.status == spq_pkg::STATUS_UNDERFLOW)
    else $error("empty remove did not report underflow");

  // taking the head drops exactly one entry
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEQ |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not drop one entry");

  // the insert walk never runs past the stored entries
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS |-> left_q != '0 && left_q <= count_q)
    else $error("insert walk out of range");

endmodule
